### rtl/core/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants for the binary to decimal ASCII block
// Holds the field widths, the ASCII offset, the limit reset value and the
// sequencer state type.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // Field widths
  localparam int VALUE_W = 16;
  localparam int DIGIT_W = 6;
  localparam int BCD_W   = 4;

  // Default digit buffer depth
  localparam int MAX_DIGITS_DEF = 5;

  // ASCII code of '0'
  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

  // Wrap limit after reset
  localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'd3000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CONV,
    S_TRIM,
    S_EMIT
  } state_t;

endpackage

### rtl/core/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned 16-bit value to decimal ASCII digits
// Optional wrap by a configured limit, then conversion and digit emission.
// ----------------------------------------------------------------------------
// One word on the input gives one to MAX_DIGITS ASCII digit words on the
// output, most significant first, no leading zeros, the last one flagged by
// last_digit. A value above a nonzero wrap_limit is first reduced modulo
// wrap_limit by a restoring remainder loop (one bit per cycle through a
// 17-bit subtract/compare). The binary value is then shifted into a BCD
// register by shift-and-add-3. Leading zero digits are dropped one per
// cycle; a value with more than MAX_DIGITS digits keeps its lowest
// MAX_DIGITS digits, zeros included. Each digit is then loaded into the
// output register whenever that register is free, so a stalled output
// holds emission; the leading zeros dropped plus the digits emitted always
// number MAX_DIGITS. in_ready is high only when the sequencer is idle; the
// last digit may still wait in the output register while the next value is
// taken. wrap_limit is written with wrap_limit_we and should only change
// while the block is idle.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // config
  input  logic               wrap_limit_we,
  input  logic [VALUE_W-1:0] wrap_limit,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  // output words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIGIT_W-1:0] ascii_digit,
  output logic               last_digit
);

  localparam int BUF_W  = MAX_DIGITS * BCD_W;
  localparam int CNT_W  = $clog2(VALUE_W);
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

  typedef struct packed {
    logic start;
    logic mod_step;
    logic conv_step;
    logic trim_step;
    logic emit_step;
  } ctl_t;

  state_t             state, state_next;
  ctl_t               ctl;
  logic [VALUE_W-1:0] limit;
  logic [VALUE_W-1:0] work;
  logic [VALUE_W-1:0] rem;
  logic [BUF_W-1:0]   bcd;
  logic               ovf;
  logic [DCNT_W-1:0]  dcnt;
  logic [CNT_W-1:0]   step_cnt;

  logic               need_wrap;
  logic               step_done;
  logic [VALUE_W:0]   trial;
  logic [VALUE_W-1:0] rem_next;
  logic [BUF_W-1:0]   bcd_adj;
  logic [BCD_W-1:0]   top_digit;
  logic               out_free;
  logic               trim_more;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (wrap_limit_we) begin
      limit <= wrap_limit;
    end
  end

  assign need_wrap = (limit != '0) && (value > limit);
  assign step_done = (step_cnt == CNT_W'(VALUE_W - 1));
  assign top_digit = bcd[BUF_W-1 -: BCD_W];
  assign out_free  = !out_valid || out_ready;
  // no trimming once digits above the buffer were dropped
  assign trim_more = !ovf && (top_digit == '0) && (dcnt > DCNT_W'(1));
  assign in_ready  = (state == S_IDLE);

  // Remainder step: shift one bit in, subtract if it fits
  always_comb begin
    trial = {rem, work[VALUE_W-1]};
    if (trial >= {1'b0, limit}) begin
      rem_next = VALUE_W'(trial - {1'b0, limit});
    end else begin
      rem_next = trial[VALUE_W-1:0];
    end
  end

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*BCD_W +: BCD_W] >= 4'd5) begin
        bcd_adj[i*BCD_W +: BCD_W] = bcd[i*BCD_W +: BCD_W] + 4'd3;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = need_wrap ? S_MOD : S_CONV;
        end
      end
      S_MOD: begin
        if (step_done) state_next = S_CONV;
      end
      S_CONV: begin
        if (step_done) state_next = S_TRIM;
      end
      S_TRIM: begin
        if (!trim_more) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free && dcnt == DCNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control decode
  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE:  ctl.start     = in_valid;
      S_MOD:   ctl.mod_step  = 1'b1;
      S_CONV:  ctl.conv_step = 1'b1;
      S_TRIM:  ctl.trim_step = trim_more;
      S_EMIT:  ctl.emit_step = out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (ctl.start) begin
      step_cnt <= '0;
    end else if (ctl.mod_step || ctl.conv_step) begin
      step_cnt <= step_done ? '0 : step_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      work <= value;
      rem  <= '0;
      bcd  <= '0;
      ovf  <= 1'b0;
    end else if (ctl.mod_step) begin
      rem  <= rem_next;
      // last step: remainder becomes the value to convert
      work <= step_done ? rem_next : {work[VALUE_W-2:0], 1'b0};
    end else if (ctl.conv_step) begin
      bcd  <= {bcd_adj[BUF_W-2:0], work[VALUE_W-1]};
      work <= {work[VALUE_W-2:0], 1'b0};
      // a one shifted out of the top digit means more digits than fit
      ovf  <= ovf | bcd_adj[BUF_W-1];
    end else if (ctl.trim_step || ctl.emit_step) begin
      bcd  <= {bcd[BUF_W-BCD_W-1:0], {BCD_W{1'b0}}};
    end
  end

  // Digits still to emit
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (ctl.conv_step && step_done) begin
      dcnt <= DCNT_W'(MAX_DIGITS);
    end else if (ctl.trim_step || ctl.emit_step) begin
      dcnt <= dcnt - DCNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_step) begin
      ascii_digit <= ASCII_ZERO + {{(DIGIT_W-BCD_W){1'b0}}, top_digit};
      last_digit  <= (dcnt == DCNT_W'(1));
    end
  end

endmodule

### rtl/core/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker: port-level checks for binary_to_decimal_ascii
// Watches the top-level ports only; attached by the bind at the end.
// ----------------------------------------------------------------------------
module b2da_checker
  import b2da_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               wrap_limit_we,
  input logic [VALUE_W-1:0] wrap_limit,
  input logic               in_valid,
  input logic               in_ready,
  input logic [VALUE_W-1:0] value,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIGIT_W-1:0] ascii_digit,
  input logic               last_digit
);

  // A shown digit is always an ASCII decimal code
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_digit >= 6'd48) && (ascii_digit <= 6'd57))
    else $error("digit word outside '0'..'9'");

  // A stalled digit word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(ascii_digit) && $stable(last_digit))
    else $error("output word changed while stalled");

  // The input is still closed at the final step of the first bit loop after a value is taken
  a_busy_conv: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##16 !in_ready)
    else $error("input reopened before conversion finished");

  // Reset leaves no digit word pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid after reset");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
